// File: hdl/htfc_pkg.sv
// Shared types and constants for the head/tail frame checker.
// No dependencies; imported by head_tail_frame_checker_core.
`default_nettype none

package htfc_pkg;

  // Buffer limits and layout
  localparam int unsigned MAX_BUFFER_BYTES = 255;
  localparam int unsigned MIN_BUFFER_BYTES = 5;
  localparam int unsigned PAYLOAD_START    = 3;
  localparam int unsigned POS_W            = 9;
  localparam logic [POS_W-1:0] POS_MAX     = '1;

  // Result queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Channel widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE = 1'd1;

  localparam logic [7:0] HEAD_BYTE_RESET = 8'hA5;
  localparam logic [7:0] TAIL_BYTE_RESET = 8'h5A;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict status codes
  typedef enum logic [2:0] {
    ST_GOOD       = 3'd0,
    ST_CHECK_BAD  = 3'd1,
    ST_FRAMING    = 3'd2,
    ST_TOO_SHORT  = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_t;

  // One result item
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] frame_id;
    logic [7:0] declared_length;
    status_t    status;
    logic       length_mismatch;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/head_tail_frame_checker_core.sv
// Head/tail frame checker top level: byte stream in, payload and verdicts out.
// Depends on htfc_pkg for constants, status codes and the result type.
// Results enter the result queue when their request is accepted; offered in order.
// Throughput: one input byte per cycle while the four-entry result queue holds
// at most two results; it takes up to two results per request and hands out one
// per cycle while out_tready is high. Reset (rst_n low, synchronous) clears the
// frame state and the queue and loads head_byte 0xA5 and tail_byte 0x5A.
`default_nettype none

module head_tail_frame_checker_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: [7:0] in_byte; in_tlast: end_of_buffer
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [htfc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                              in_tlast,
  // out_tdata: [7:0] payload_byte, [15:8] frame_id, [23:16] declared_length,
  //            [26:24] status, [27] length_mismatch, [31:28] zero
  // out_tuser: kind; out_tlast: last
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [htfc_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                   out_tuser,
  output logic                                   out_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [htfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [htfc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import htfc_pkg::*;

  logic [7:0]       head_r, tail_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             hm_r, hm_nxt;
  logic [7:0]       d0_r, d0_nxt, d1_r, d1_nxt;
  logic             par_r, par_nxt;
  logic [7:0]       id_r, id_nxt, len_r, len_nxt;

  result_t          q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r, wr_nxt, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  logic       accept, pop;
  logic [7:0] in_b;
  logic       in_end;
  logic       hm_cur;
  logic [7:0] id_cur, len_cur;
  logic       emit_pay, par_cur;
  logic [POS_W:0] total, count;
  logic       too_short, too_long, framing_bad, check_bad;
  status_t    st;
  result_t    pay_res, ver_res;
  logic [QPTR_W-1:0] ver_slot;
  logic [1:0] n_push;

  assign in_b   = in_tdata[7:0];
  assign in_end = in_tlast;
  assign accept = in_tvalid && in_tready;
  assign pop    = out_tvalid && out_tready;

  // Leave room for two results per request
  assign in_tready  = (cnt_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign out_tvalid = (cnt_r != '0);

  // Drive the output from the queue head
  always_comb begin
    out_tdata = '0;
    out_tdata[7:0]   = q_r[rd_r].payload_byte;
    out_tdata[15:8]  = q_r[rd_r].frame_id;
    out_tdata[23:16] = q_r[rd_r].declared_length;
    out_tdata[26:24] = q_r[rd_r].status;
    out_tdata[27]    = q_r[rd_r].length_mismatch;
    out_tuser        = q_r[rd_r].kind;
    out_tlast        = q_r[rd_r].last;
  end

  // Header fields as seen after this byte
  always_comb begin
    hm_cur  = (pos_r == POS_W'(0)) ? (in_b == head_r) : hm_r;
    id_cur  = (pos_r == POS_W'(1)) ? in_b : id_r;
    len_cur = (pos_r == POS_W'(2)) ? in_b : len_r;
  end

  // Byte two back is payload once the current byte exists
  assign emit_pay = accept && (pos_r >= POS_W'(PAYLOAD_START + 2)) && hm_cur;
  assign par_cur  = (pos_r >= POS_W'(PAYLOAD_START + 2)) ? (par_r ^ d1_r[0]) : par_r;

  // Verdict
  always_comb begin
    total       = {1'b0, pos_r} + (POS_W+1)'(1);
    too_short   = (total < (POS_W+1)'(MIN_BUFFER_BYTES));
    too_long    = (total > (POS_W+1)'(MAX_BUFFER_BYTES));
    count       = too_short ? '0 : total - (POS_W+1)'(MIN_BUFFER_BYTES);
    framing_bad = !hm_cur || (in_b != tail_r);
    check_bad   = (d0_r != {7'd0, par_cur});
    if (too_short) begin
      st = ST_TOO_SHORT;
    end else if (too_long) begin
      st = ST_TOO_LONG;
    end else if (framing_bad) begin
      st = ST_FRAMING;
    end else if (check_bad) begin
      st = ST_CHECK_BAD;
    end else begin
      st = ST_GOOD;
    end
  end

  always_comb begin
    pay_res                 = '0;
    pay_res.kind            = KIND_PAYLOAD;
    pay_res.payload_byte    = d1_r;
    pay_res.last            = !in_end;
    ver_res                 = '0;
    ver_res.kind            = KIND_VERDICT;
    ver_res.frame_id        = id_cur;
    ver_res.declared_length = len_cur;
    ver_res.status          = st;
    ver_res.length_mismatch = (count != {2'b00, len_cur});
    ver_res.last            = 1'b1;
  end

  // Queue pointers and fill count
  always_comb begin
    n_push   = {1'b0, emit_pay} + {1'b0, accept && in_end};
    ver_slot = wr_r + QPTR_W'(emit_pay);
    wr_nxt   = wr_r + QPTR_W'(n_push);
    rd_nxt   = rd_r + QPTR_W'(pop);
    cnt_nxt  = cnt_r + QCNT_W'(n_push) - QCNT_W'(pop);
  end

  // Frame state update
  always_comb begin
    pos_nxt = pos_r;
    hm_nxt  = hm_r;
    d0_nxt  = d0_r;
    d1_nxt  = d1_r;
    par_nxt = par_r;
    id_nxt  = id_r;
    len_nxt = len_r;
    if (accept) begin
      if (in_end) begin
        pos_nxt = '0;
        hm_nxt  = 1'b0;
        d0_nxt  = '0;
        d1_nxt  = '0;
        par_nxt = 1'b0;
        id_nxt  = '0;
        len_nxt = '0;
      end else begin
        hm_nxt  = hm_cur;
        id_nxt  = id_cur;
        len_nxt = len_cur;
        par_nxt = par_cur;
        d1_nxt  = d0_r;
        d0_nxt  = in_b;
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= HEAD_BYTE_RESET;
      tail_r <= TAIL_BYTE_RESET;
      pos_r  <= '0;
      hm_r   <= 1'b0;
      d0_r   <= '0;
      d1_r   <= '0;
      par_r  <= 1'b0;
      id_r   <= '0;
      len_r  <= '0;
      wr_r   <= '0;
      rd_r   <= '0;
      cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HEAD_BYTE: head_r <= cfg_wdata[7:0];
          REG_TAIL_BYTE: tail_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      pos_r <= pos_nxt;
      hm_r  <= hm_nxt;
      d0_r  <= d0_nxt;
      d1_r  <= d1_nxt;
      par_r <= par_nxt;
      id_r  <= id_nxt;
      len_r <= len_nxt;
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Write results into the queue slots
  always_ff @(posedge clk) begin
    if (emit_pay) begin
      q_r[wr_r] <= pay_res;
    end
    if (accept && in_end) begin
      q_r[ver_slot] <= ver_res;
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end |=> pos_r == '0 && !hm_r && !par_r)
    else $error("frame state not cleared after end byte");

  a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end && !pop |=> cnt_r > $past(cnt_r))
    else $error("end byte gave no verdict");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_end && pos_r == '0 |=> pos_r == POS_W'(1))
    else $error("byte position did not advance");

endmodule

`default_nettype wire

// File: test/head_tail_frame_checker_core_tb.sv
// Self-checking bench for head_tail_frame_checker_core: drives byte buffers, predicts
// payload and verdict results in step with the stream, and compares them on the fly.
// Depends on htfc_pkg and head_tail_frame_checker_core.
`default_nettype none

module head_tail_frame_checker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htfc_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // [7:0] in_byte
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // [7:0] payload_byte, [15:8] frame_id,
                                      // [23:16] declared_length, [26:24] status,
                                      // [27] length_mismatch
  logic                  out_tuser;   // kind
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  head_tail_frame_checker_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Frame state mirrored from the block
  logic [7:0]       head_cfg;
  logic [7:0]       tail_cfg;
  logic [POS_W-1:0] fr_pos;
  logic             fr_head_ok;
  logic [7:0]       fr_prev;
  logic [7:0]       fr_prev2;
  logic             fr_parity;
  logic [7:0]       fr_id;
  logic [7:0]       fr_len;

  result_t    awaited_results[$];
  result_t    want;
  logic [7:0] frame_bytes[$];
  int         fail_count;
  int         sent_count;
  bit         gaps_on;
  int         sink_hold;
  int         sink_wait;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Generous limit on the whole run
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_frame_state();
    fr_pos     = '0;
    fr_head_ok = 1'b0;
    fr_prev    = '0;
    fr_prev2   = '0;
    fr_parity  = 1'b0;
    fr_id      = '0;
    fr_len     = '0;
  endfunction

  // Work out the results that one accepted byte causes and queue them
  function automatic void predict_checker_byte(logic [7:0] b, logic eob);
    result_t outs[2];
    result_t r;
    int      n;
    int      total;
    int      count;
    status_t st;
    n = 0;
    if (fr_pos == 0) fr_head_ok = (b == head_cfg);
    else if (fr_pos == 1) fr_id = b;
    else if (fr_pos == 2) fr_len = b;

    // byte two places back is payload once a byte follows it beyond the check
    if (fr_pos >= PAYLOAD_START + 2) begin
      fr_parity = fr_parity ^ fr_prev2[0];
      if (fr_head_ok) begin
        r = '0;
        r.kind = KIND_PAYLOAD;
        r.payload_byte = fr_prev2;
        outs[n] = r;
        n++;
      end
    end

    if (eob) begin
      total = int'(fr_pos) + 1;
      count = (total >= MIN_BUFFER_BYTES) ? total - MIN_BUFFER_BYTES : 0;
      if (total < MIN_BUFFER_BYTES) st = ST_TOO_SHORT;
      else if (total > MAX_BUFFER_BYTES) st = ST_TOO_LONG;
      else if (!fr_head_ok || b != tail_cfg) st = ST_FRAMING;
      else if (fr_prev != {7'b0, fr_parity}) st = ST_CHECK_BAD;
      else st = ST_GOOD;
      r = '0;
      r.kind = KIND_VERDICT;
      r.frame_id = fr_id;
      r.declared_length = fr_len;
      r.status = st;
      r.length_mismatch = (count != int'(fr_len));
      outs[n] = r;
      n++;
      clear_frame_state();
    end else begin
      fr_prev2 = fr_prev;
      fr_prev  = b;
      if (fr_pos != POS_MAX) fr_pos = fr_pos + 1'b1;
    end

    if (n > 0) outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) awaited_results.push_back(outs[i]);
  endfunction

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $error("result 0x%0h with nothing awaited", out_tdata);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_tuser));
        check_field("payload_byte", 32'(want.payload_byte), 32'(out_tdata[7:0]));
        check_field("frame_id", 32'(want.frame_id), 32'(out_tdata[15:8]));
        check_field("declared_length", 32'(want.declared_length),
                    32'(out_tdata[23:16]));
        check_field("status", 32'(want.status), 32'(out_tdata[26:24]));
        check_field("length_mismatch", 32'(want.length_mismatch), 32'(out_tdata[27]));
        check_field("last", 32'(want.last), 32'(out_tlast));
      end
    end
  end

  // Receiver: long hold-off on request, otherwise random stalls
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        sink_hold--;
      end else if (sink_wait > 0) begin
        out_tready <= 1'b0;
        sink_wait--;
      end else begin
        out_tready <= 1'b1;
        if (gaps_on) sink_wait = pick_gap();
      end
    end
  end

  // Offer one byte, hold it until the request is taken, then predict
  task automatic send_byte(input logic [7:0] b, input logic eob);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(0, 255));
      in_tlast  <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eob;
    do @(posedge clk); while (!in_tready);
    predict_checker_byte(b, eob);
    sent_count++;
  endtask

  task automatic send_frame_bytes();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Lay out head, id, length, random payload, check and tail
  task automatic build_frame(input logic [7:0] head, input logic [7:0] id,
                             input logic [7:0] dlen, input int n_pay,
                             input bit good_check, input logic [7:0] tail);
    logic [7:0] b;
    logic [7:0] chk;
    logic       par;
    par = 1'b0;
    frame_bytes = {};
    frame_bytes.push_back(head);
    frame_bytes.push_back(id);
    frame_bytes.push_back(dlen);
    repeat (n_pay) begin
      b = 8'($urandom_range(0, 255));
      frame_bytes.push_back(b);
      par = par ^ b[0];
    end
    chk = {7'b0, par};
    if (!good_check) begin
      chk = 8'($urandom_range(0, 255));
      if (chk == {7'b0, par}) chk = chk ^ 8'h80;
    end
    frame_bytes.push_back(chk);
    frame_bytes.push_back(tail);
  endtask

  // Mostly well-formed frames with random content, some corrupted, some noise
  task automatic send_random_frame();
    int         r;
    int         n_pay;
    logic [7:0] dlen;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      n_pay = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      dlen  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'(n_pay);
      build_frame(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : head_cfg,
                  8'($urandom_range(0, 255)), dlen, n_pay, $urandom_range(0, 9) != 0,
                  ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : tail_cfg);
    end else begin
      frame_bytes = {};
      repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) frame_bytes[0] = head_cfg;
    end
    send_frame_bytes();
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_HEAD_BYTE) head_cfg = val;
    else tail_cfg = val;
  endtask

  // Every status but too long, short buffers, extremes of the byte values
  task automatic test_directed();
    // single head byte: too short, id and length never seen
    frame_bytes = '{8'hA5};
    send_frame_bytes();
    // four bytes: too short
    frame_bytes = '{8'h00, 8'hFF, 8'h22, 8'h33};
    send_frame_bytes();
    // good frame with payload 0xFF, odd parity
    frame_bytes = '{8'hA5, 8'h7E, 8'h01, 8'hFF, 8'h01, 8'h5A};
    send_frame_bytes();
    // check byte compared as a whole byte: 0x03 against parity 1
    frame_bytes = '{8'hA5, 8'h02, 8'h01, 8'h11, 8'h03, 8'h5A};
    send_frame_bytes();
    // head mismatch: no payload, verdict still given
    frame_bytes = '{8'hA4, 8'h03, 8'h00, 8'h00, 8'h5A};
    send_frame_bytes();
    // tail mismatch with a declared length that differs
    frame_bytes = '{8'hA5, 8'h04, 8'h07, 8'h00, 8'h5B};
    send_frame_bytes();
    settle();
  endtask

  // Extreme and random register settings, each followed by frames
  task automatic test_config();
    write_reg(REG_HEAD_BYTE, 8'h00);
    write_reg(REG_TAIL_BYTE, 8'hFF);
    build_frame(head_cfg, 8'h10, 8'd2, 2, 1'b1, tail_cfg);
    send_frame_bytes();
    build_frame(8'hA5, 8'h11, 8'd1, 1, 1'b1, tail_cfg);
    send_frame_bytes();
    write_reg(REG_HEAD_BYTE, 8'hFF);
    write_reg(REG_TAIL_BYTE, 8'h00);
    build_frame(head_cfg, 8'h20, 8'd3, 3, 1'b1, tail_cfg);
    send_frame_bytes();
    build_frame(head_cfg, 8'h21, 8'd0, 0, 1'b1, 8'hFF);
    send_frame_bytes();
    write_reg(REG_HEAD_BYTE, 8'($urandom_range(0, 255)));
    write_reg(REG_TAIL_BYTE, 8'($urandom_range(0, 255)));
    repeat (4) send_random_frame();
    settle();
  endtask

  // Random frames, register settings changed between stretches
  task automatic test_random_frames();
    int start;
    int next_cfg;
    start    = sent_count;
    next_cfg = sent_count + 150;
    while (sent_count - start < 500) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      send_random_frame();
      if (sent_count >= next_cfg) begin
        write_reg(REG_HEAD_BYTE, 8'($urandom_range(0, 255)));
        write_reg(REG_TAIL_BYTE, 8'($urandom_range(0, 255)));
        next_cfg = sent_count + 150;
      end
    end
    gaps_on = 1'b1;
    settle();
  endtask

  // Receiver holds off while the sender keeps offering, then the sender pauses
  task automatic test_backpressure();
    gaps_on = 1'b0;
    sink_hold = 80;
    repeat (3) begin
      build_frame(head_cfg, 8'($urandom_range(0, 255)), 8'd10, 10, 1'b1, tail_cfg);
      send_frame_bytes();
    end
    settle();
    repeat (3) send_random_frame();
    gaps_on = 1'b1;
    settle();
  endtask

  // Largest good buffer, one over, and one long enough to saturate the counter
  task automatic test_long_buffers();
    build_frame(head_cfg, 8'hC3, 8'd250, 250, 1'b1, tail_cfg);
    send_frame_bytes();
    build_frame(head_cfg, 8'h3C, 8'd251, 251, 1'b1, tail_cfg);
    send_frame_bytes();
    build_frame(head_cfg, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 515,
                1'b1, tail_cfg);
    send_frame_bytes();
    settle();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    fail_count = 0;
    sent_count = 0;
    gaps_on    = 1'b1;
    sink_hold  = 0;
    sink_wait  = 0;
    head_cfg   = HEAD_BYTE_RESET;
    tail_cfg   = TAIL_BYTE_RESET;
    clear_frame_state();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_config();
    test_random_frames();
    test_backpressure();
    test_long_buffers();

    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
